// File: rtl/biu_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear image upscale: shared definitions
// Source image geometry, derived widths, register and opcode codes, the
// sequencer states and the request and response words of the position divider.
// ----------------------------------------------------------------------------
package biu_pkg;

    // Source image geometry.
    localparam int SRC_WIDTH  = 320;
    localparam int SRC_HEIGHT = 240;
    localparam int SRC_PIXELS = SRC_WIDTH * SRC_HEIGHT;
    localparam int SRC_MAX    = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;

    // Field widths.
    localparam int SIZE_W = 13;   // frame size registers
    localparam int COORD_W = 12;  // requested output coordinates
    localparam int FRAC_W = 8;    // fraction of a source position
    localparam int CHAN_W = 8;    // one color channel

    // The 9.8 source position never exceeds (SRC_MAX - 1) * 256.
    localparam int POS_W  = $clog2((SRC_MAX - 1) * 256 + 1);
    localparam int CRD_W  = POS_W - FRAC_W;
    localparam int NUM_W  = COORD_W + POS_W;
    localparam int ADDR_W = $clog2(SRC_PIXELS);
    localparam int CNT_W  = $clog2(POS_W + 1);

    localparam logic [SIZE_W-1:0] OUT_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] OUT_HEIGHT_RST = 13'd480;
    localparam logic [CHAN_W-1:0] ALPHA_BYTE     = 8'hFF;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CRD_W-1:0]  t_crd;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Configuration register indexes.
    typedef enum logic {
        CFG_OUT_WIDTH  = 1'b0,
        CFG_OUT_HEIGHT = 1'b1
    } t_cfg_idx;

    // Input word opcodes.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    // Fetch sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ADDR,
        ST_RD00,
        ST_RD01,
        ST_RD10,
        ST_RD11,
        ST_BOT,
        ST_MIX
    } t_state;

    // Divider request and response.
    typedef struct packed {
        logic  start;
        t_num  num;
        t_size den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        t_pos quot;
    } t_div_rsp;

endpackage

// File: rtl/biu_div.sv
// ----------------------------------------------------------------------------
// Bilinear image upscale: source position divider
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in POS_W bits, so the walk starts at that bit.
// ----------------------------------------------------------------------------
module biu_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  biu_pkg::t_div_req  i_req,
    output biu_pkg::t_div_rsp  o_rsp
);

    logic                 r_busy;
    biu_pkg::t_cnt        r_cnt;
    biu_pkg::t_size       r_rem;
    biu_pkg::t_pos        r_nq;
    biu_pkg::t_size       r_den;

    logic [biu_pkg::SIZE_W:0] trial;
    logic [biu_pkg::SIZE_W:0] diff;
    logic                     ge;

    // Shift in the next numerator bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_nq[biu_pkg::POS_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= biu_pkg::t_cnt'(biu_pkg::POS_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == biu_pkg::t_cnt'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Partial remainder and the numerator bits that turn into quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= biu_pkg::t_size'(i_req.num[biu_pkg::NUM_W-1:biu_pkg::POS_W]);
            r_nq  <= i_req.num[biu_pkg::POS_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[biu_pkg::SIZE_W-1:0] : trial[biu_pkg::SIZE_W-1:0];
            r_nq  <= {r_nq[biu_pkg::POS_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_nq;

endmodule

// File: rtl/bilinear_image_upscale.sv
// ----------------------------------------------------------------------------
// Bilinear image upscale
// Holds a 320 x 240 RGB source image and returns bilinearly resampled pixels
// of a configurable output frame, packed as ARGB with opaque alpha.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries a word with an opcode. A load word writes one
// source pixel at src_index; loads may follow each other in every cycle
// while no fetch runs. A load index past the image is ignored.
// A fetch word asks for output pixel (out_x, out_y); coordinates past the
// frame saturate to its last column or row. Once the fetch is taken, the
// sequencer forms the coordinate products, waits for the bit-serial position
// dividers (POS_W = 17 steps) to finish, does the address math, makes four
// reads of the single-port image store, blends the second row and then
// blends vertically. The input channel stalls for the whole fetch, so the
// next word is taken only after the fetch has ended.
// The user must write the frame size registers through the configuration
// port only while the block is idle; the block itself does not enforce it.
// Reset restores a 640 x 480 frame; the image store keeps its contents and
// is undefined until loaded. When the receiver stalls, the finished word
// waits in the output register and the next fetch may still run until it
// needs that register.
// ----------------------------------------------------------------------------
module bilinear_image_upscale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [16:0] i_src_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [11:0] i_out_x,
    input  logic [11:0] i_out_y,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_argb_pixel,
    // Configuration port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    // Blend one channel: a + floor((b - a) * f / 256).
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic signed [9:0]  d;
        logic signed [18:0] p;
        d = signed'({2'b00, b}) - signed'({2'b00, a});
        p = d * signed'({1'b0, f});
        return a + p[15:8];
    endfunction

    biu_pkg::t_state    r_state;
    biu_pkg::t_state    n_state;

    biu_pkg::t_size     r_out_width;
    biu_pkg::t_size     r_out_height;

    biu_pkg::t_coord    r_cx;
    biu_pkg::t_coord    r_cy;
    biu_pkg::t_size     r_dx;
    biu_pkg::t_size     r_dy;

    biu_pkg::t_crd      r_x0;
    biu_pkg::t_crd      r_x1;
    biu_pkg::t_addr     r_row0;
    biu_pkg::t_addr     r_row1;
    logic [7:0]         r_fx;
    logic [7:0]         r_fy;

    logic [23:0]        r_mem [0:biu_pkg::SRC_PIXELS-1];
    logic [23:0]        r_rdata;
    logic [23:0]        r_p0;
    logic [23:0]        r_top;
    logic [23:0]        r_bot;

    logic               r_out_valid;
    logic [31:0]        r_argb;

    biu_pkg::t_div_req  div_x_req;
    biu_pkg::t_div_req  div_y_req;
    biu_pkg::t_div_rsp  div_x_rsp;
    biu_pkg::t_div_rsp  div_y_rsp;

    logic               in_take;
    logic               take_fetch;
    logic               mem_we;
    logic               mem_re;
    biu_pkg::t_addr     rd_addr;
    logic               div_start;
    logic               out_load;
    logic               out_free;

    biu_pkg::t_size     cmax_x;
    biu_pkg::t_size     cmax_y;
    biu_pkg::t_coord    cx;
    biu_pkg::t_coord    cy;
    biu_pkg::t_crd      x0_raw;
    biu_pkg::t_crd      y0_raw;
    biu_pkg::t_crd      x0;
    biu_pkg::t_crd      y0;
    biu_pkg::t_crd      x1;
    biu_pkg::t_crd      y1;
    logic [23:0]        lerp_fx;
    logic [23:0]        mix;

    // Input handshake.
    assign o_stall    = (r_state != biu_pkg::ST_IDLE);
    assign in_take    = i_valid && !o_stall;
    assign take_fetch = in_take && (biu_pkg::t_opcode'(i_opcode) == biu_pkg::OP_FETCH);
    assign mem_we     = in_take && (biu_pkg::t_opcode'(i_opcode) == biu_pkg::OP_LOAD) &&
                        (i_src_index < biu_pkg::t_addr'(biu_pkg::SRC_PIXELS));
    assign out_free   = !r_out_valid || !i_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= biu_pkg::OUT_WIDTH_RST;
            r_out_height <= biu_pkg::OUT_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (biu_pkg::t_cfg_idx'(i_cfg_index))
                biu_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                biu_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
            endcase
        end
    end

    // Clamp the coordinates to the frame and pick the divisors.
    always_comb begin
        cmax_x = (r_out_width == '0) ? '0 : r_out_width - 1'b1;
        cmax_y = (r_out_height == '0) ? '0 : r_out_height - 1'b1;
        cx = ({1'b0, i_out_x} > cmax_x) ? cmax_x[biu_pkg::COORD_W-1:0] : i_out_x;
        cy = ({1'b0, i_out_y} > cmax_y) ? cmax_y[biu_pkg::COORD_W-1:0] : i_out_y;
    end

    always_ff @(posedge i_clk) begin
        if (take_fetch) begin
            r_cx <= cx;
            r_cy <= cy;
            r_dx <= (r_out_width > biu_pkg::t_size'(1)) ? cmax_x : biu_pkg::t_size'(1);
            r_dy <= (r_out_height > biu_pkg::t_size'(1)) ? cmax_y : biu_pkg::t_size'(1);
        end
    end

    // Position dividers: coord * (S - 1) * 256 / divisor.
    assign div_x_req.start = div_start;
    assign div_x_req.num   = (biu_pkg::t_num'(r_cx) *
                              biu_pkg::t_num'(biu_pkg::SRC_WIDTH - 1)) << biu_pkg::FRAC_W;
    assign div_x_req.den   = r_dx;
    assign div_y_req.start = div_start;
    assign div_y_req.num   = (biu_pkg::t_num'(r_cy) *
                              biu_pkg::t_num'(biu_pkg::SRC_HEIGHT - 1)) << biu_pkg::FRAC_W;
    assign div_y_req.den   = r_dy;

    biu_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_x_req),
        .o_rsp   (div_x_rsp)
    );

    biu_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_y_req),
        .o_rsp   (div_y_rsp)
    );

    // Neighbor coordinates, held at the last column and row.
    always_comb begin
        x0_raw = div_x_rsp.quot[biu_pkg::POS_W-1:biu_pkg::FRAC_W];
        y0_raw = div_y_rsp.quot[biu_pkg::POS_W-1:biu_pkg::FRAC_W];
        x0 = (x0_raw > biu_pkg::t_crd'(biu_pkg::SRC_WIDTH - 1)) ?
             biu_pkg::t_crd'(biu_pkg::SRC_WIDTH - 1) : x0_raw;
        y0 = (y0_raw > biu_pkg::t_crd'(biu_pkg::SRC_HEIGHT - 1)) ?
             biu_pkg::t_crd'(biu_pkg::SRC_HEIGHT - 1) : y0_raw;
        x1 = (x0 < biu_pkg::t_crd'(biu_pkg::SRC_WIDTH - 1)) ? x0 + 1'b1 : x0;
        y1 = (y0 < biu_pkg::t_crd'(biu_pkg::SRC_HEIGHT - 1)) ? y0 + 1'b1 : y0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == biu_pkg::ST_ADDR) begin
            r_x0   <= x0;
            r_x1   <= x1;
            r_row0 <= biu_pkg::t_addr'(y0) * biu_pkg::t_addr'(biu_pkg::SRC_WIDTH);
            r_row1 <= biu_pkg::t_addr'(y1) * biu_pkg::t_addr'(biu_pkg::SRC_WIDTH);
            r_fx   <= div_x_rsp.quot[biu_pkg::FRAC_W-1:0];
            r_fy   <= div_y_rsp.quot[biu_pkg::FRAC_W-1:0];
        end
    end

    // Image store: one write or one read per cycle, registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_src_index] <= {i_red_in, i_green_in, i_blue_in};
        end
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Horizontal blend of the held left pixel with the word just read, and vertical blend of the two rows.
    always_comb begin
        lerp_fx[23:16] = lerp8(r_p0[23:16], r_rdata[23:16], r_fx);
        lerp_fx[15:8]  = lerp8(r_p0[15:8],  r_rdata[15:8],  r_fx);
        lerp_fx[7:0]   = lerp8(r_p0[7:0],   r_rdata[7:0],   r_fx);
        mix[23:16]     = lerp8(r_top[23:16], r_bot[23:16], r_fy);
        mix[15:8]      = lerp8(r_top[15:8],  r_bot[15:8],  r_fy);
        mix[7:0]       = lerp8(r_top[7:0],   r_bot[7:0],   r_fy);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == biu_pkg::ST_RD01 || r_state == biu_pkg::ST_RD11) begin
            r_p0 <= r_rdata;
        end
        if (r_state == biu_pkg::ST_RD10) begin
            r_top <= lerp_fx;
        end
        if (r_state == biu_pkg::ST_BOT) begin
            r_bot <= lerp_fx;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= biu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            biu_pkg::ST_IDLE: begin
                if (take_fetch) begin
                    n_state = biu_pkg::ST_MUL;
                end
            end
            biu_pkg::ST_MUL:  n_state = biu_pkg::ST_DIV;
            biu_pkg::ST_DIV: begin
                if (!div_x_rsp.busy && !div_y_rsp.busy) begin
                    n_state = biu_pkg::ST_ADDR;
                end
            end
            biu_pkg::ST_ADDR: n_state = biu_pkg::ST_RD00;
            biu_pkg::ST_RD00: n_state = biu_pkg::ST_RD01;
            biu_pkg::ST_RD01: n_state = biu_pkg::ST_RD10;
            biu_pkg::ST_RD10: n_state = biu_pkg::ST_RD11;
            biu_pkg::ST_RD11: n_state = biu_pkg::ST_BOT;
            biu_pkg::ST_BOT:  n_state = biu_pkg::ST_MIX;
            biu_pkg::ST_MIX: begin
                if (out_free) begin
                    n_state = biu_pkg::ST_IDLE;
                end
            end
            default: n_state = biu_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        div_start = 1'b0;
        mem_re    = 1'b0;
        rd_addr   = r_row0 + biu_pkg::t_addr'(r_x0);
        out_load  = 1'b0;
        unique case (r_state)
            biu_pkg::ST_MUL:  div_start = 1'b1;
            biu_pkg::ST_RD00: mem_re = 1'b1;
            biu_pkg::ST_RD01: begin
                mem_re  = 1'b1;
                rd_addr = r_row0 + biu_pkg::t_addr'(r_x1);
            end
            biu_pkg::ST_RD10: begin
                mem_re  = 1'b1;
                rd_addr = r_row1 + biu_pkg::t_addr'(r_x0);
            end
            biu_pkg::ST_RD11: begin
                mem_re  = 1'b1;
                rd_addr = r_row1 + biu_pkg::t_addr'(r_x1);
            end
            biu_pkg::ST_MIX:  out_load = out_free;
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_argb <= {biu_pkg::ALPHA_BYTE, mix};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_argb_pixel = r_argb;

endmodule
